// ----- src/vbbn_pkg.sv -----
`timescale 1ns / 1ps
package vbbn_pkg;

	localparam int COORD_WIDTH_DEF   = 32;
	localparam int OUT_FRAC_BITS_DEF = 14;

	localparam logic [1:0] ACT_CLEAR   = 2'd0;
	localparam logic [1:0] ACT_MEASURE = 2'd1;
	localparam logic [1:0] ACT_CONVERT = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXT_X,
		ST_DIF_Y,
		ST_MAX_Y,
		ST_DIF_Z,
		ST_MAX_Z,
		ST_CHECK,
		ST_NUM_A,
		ST_NUM_B,
		ST_ABS,
		ST_TEST,
		ST_DIV,
		ST_STORE,
		ST_OUT
	} vbbn_state_t;

endpackage

// ----- src/vertex_bounding_box_normalizer.sv -----
`timescale 1ns / 1ps
// Vertex bounding-box normalizer: maps a mesh into the unit cube in two passes.
// Input channel s_*: s_tuser carries the action (clear bounds, measure vertex,
// convert vertex), s_tdata the vertex x, y, z in signed Q15.16.
// Output channel m_*: one item per convert, m_tdata holding the normalized x, y, z
// in signed Q1.OUT_FRAC_BITS, m_tuser the degenerate flag.
// Clear and measure items are taken one per cycle while idle and give no output item.
// A convert item runs on one shared subtractor under a sequencer: five steps find
// the largest extent, one step checks it, then each axis takes four steps, one
// restoring-divide step per quotient bit (OUT_FRAC_BITS) unless it saturates, and
// a store step, then an output step loads the output register. s_tready stays low
// from acceptance until the output item is loaded; a degenerate extent goes from
// the check step straight to the output step.
// The output item sits in a register; a stalled receiver holds it while the next
// items are taken, and a further convert waits at its last step until it drains.
// Reset clears the bounds to their empty values (minimum at the most positive,
// maximum at the most negative value) and drops any pending output item.
module vertex_bounding_box_normalizer
	import vbbn_pkg::*;
#(
	parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
	parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF,
	localparam int IN_DATA_W    = ((3 * COORD_WIDTH + 7) / 8) * 8,
	localparam int NW           = OUT_FRAC_BITS + 2,
	localparam int OUT_DATA_W   = ((3 * NW + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // coord_x, coord_y, coord_z, zero pad
	input  logic [1:0]            s_tuser,   // action
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // norm_x, norm_y, norm_z, zero pad
	output logic                  m_tuser    // degenerate
);

	localparam int W     = COORD_WIDTH + 2;
	localparam int CNT_W = $clog2(OUT_FRAC_BITS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OUT_FRAC_BITS - 1);
	localparam logic [1:0] AXIS_LAST = 2'd2;
	localparam logic [COORD_WIDTH-1:0] CRD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic [COORD_WIDTH-1:0] CRD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
	localparam logic [OUT_FRAC_BITS:0] QUO_ONE = {1'b1, {OUT_FRAC_BITS{1'b0}}};

	vbbn_state_t state_q, state_d;

	logic [COORD_WIDTH-1:0] in_crd [3];
	logic [COORD_WIDTH-1:0] crd_q [3];
	logic [COORD_WIDTH-1:0] lo_q [3];
	logic [COORD_WIDTH-1:0] hi_q [3];
	logic [COORD_WIDTH-1:0] cur_v, cur_lo, cur_hi;
	logic [1:0]             axis_q;
	logic [W-1:0]           ext_q, tmp_q, rem_q;
	logic                   neg_q;
	logic [OUT_FRAC_BITS:0] quo_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [NW-1:0]          nrm_q [3];
	logic                   deg_q;
	logic [NW-1:0]          res_q [3];
	logic                   res_deg_q;
	logic                   m_tvalid_q;
	logic [NW-1:0]          quo_ext;

	logic [W-1:0] op_a, op_b, sum;
	logic         op_sub;
	logic         in_acc, out_load, ext_bad;

	function automatic logic [W-1:0] sx(input logic [COORD_WIDTH-1:0] c);
		sx = {{2{c[COORD_WIDTH-1]}}, c};
	endfunction

	assign in_acc  = s_tvalid && s_tready;
	assign cur_v   = crd_q[axis_q];
	assign cur_lo  = lo_q[axis_q];
	assign cur_hi  = hi_q[axis_q];
	assign ext_bad = ext_q[W-1] || (ext_q == '0);
	assign quo_ext = {1'b0, quo_q};

	for (genvar i = 0; i < 3; i++) begin : g_unpack
		assign in_crd[i] = s_tdata[i*COORD_WIDTH +: COORD_WIDTH];
	end

	// shared subtractor operands
	always_comb begin
		op_a   = '0;
		op_b   = '0;
		op_sub = 1'b0;
		case (state_q)
			ST_EXT_X: begin
				op_a   = sx(hi_q[0]);
				op_b   = sx(lo_q[0]);
				op_sub = 1'b1;
			end
			ST_DIF_Y: begin
				op_a   = sx(hi_q[1]);
				op_b   = sx(lo_q[1]);
				op_sub = 1'b1;
			end
			ST_DIF_Z: begin
				op_a   = sx(hi_q[2]);
				op_b   = sx(lo_q[2]);
				op_sub = 1'b1;
			end
			ST_MAX_Y, ST_MAX_Z: begin
				op_a   = tmp_q;
				op_b   = ext_q;
				op_sub = 1'b1;
			end
			ST_NUM_A: begin
				op_a   = {cur_v[COORD_WIDTH-1], cur_v, 1'b0};
				op_b   = sx(cur_hi);
				op_sub = 1'b1;
			end
			ST_NUM_B: begin
				op_a   = tmp_q;
				op_b   = sx(cur_lo);
				op_sub = 1'b1;
			end
			ST_ABS: begin
				op_a   = '0;
				op_b   = tmp_q;
				op_sub = tmp_q[W-1];
			end
			ST_TEST: begin
				op_a   = rem_q;
				op_b   = ext_q;
				op_sub = 1'b1;
			end
			ST_DIV: begin
				op_a   = {rem_q[W-2:0], 1'b0};
				op_b   = ext_q;
				op_sub = 1'b1;
			end
			default: begin
				op_a   = '0;
				op_b   = '0;
				op_sub = 1'b0;
			end
		endcase
	end

	assign sum = op_a + (op_sub ? ~op_b : op_b) + W'(op_sub);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && s_tuser == ACT_CONVERT) begin
					state_d = ST_EXT_X;
				end
			end
			ST_EXT_X: state_d = ST_DIF_Y;
			ST_DIF_Y: state_d = ST_MAX_Y;
			ST_MAX_Y: state_d = ST_DIF_Z;
			ST_DIF_Z: state_d = ST_MAX_Z;
			ST_MAX_Z: state_d = ST_CHECK;
			ST_CHECK: state_d = ext_bad ? ST_OUT : ST_NUM_A;
			ST_NUM_A: state_d = ST_NUM_B;
			ST_NUM_B: state_d = ST_ABS;
			ST_ABS:   state_d = ST_TEST;
			ST_TEST:  state_d = sum[W-1] ? ST_DIV : ST_STORE;
			ST_DIV: begin
				if (cnt_q == CNT_LAST) begin
					state_d = ST_STORE;
				end
			end
			ST_STORE: state_d = (axis_q == AXIS_LAST) ? ST_OUT : ST_NUM_A;
			ST_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// bounds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				lo_q[i] <= CRD_MAX;
				hi_q[i] <= CRD_MIN;
			end
		end else if (in_acc) begin
			case (s_tuser)
				ACT_CLEAR: begin
					for (int i = 0; i < 3; i++) begin
						lo_q[i] <= CRD_MAX;
						hi_q[i] <= CRD_MIN;
					end
				end
				ACT_MEASURE: begin
					for (int i = 0; i < 3; i++) begin
						if ($signed(in_crd[i]) < $signed(lo_q[i])) begin
							lo_q[i] <= in_crd[i];
						end
						if ($signed(in_crd[i]) > $signed(hi_q[i])) begin
							hi_q[i] <= in_crd[i];
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					for (int i = 0; i < 3; i++) begin
						crd_q[i] <= in_crd[i];
					end
				end
				axis_q <= '0;
			end
			ST_EXT_X: ext_q <= sum;
			ST_DIF_Y, ST_DIF_Z: tmp_q <= sum;
			ST_MAX_Y, ST_MAX_Z: begin
				if (!sum[W-1]) begin
					ext_q <= tmp_q;
				end
			end
			ST_CHECK: begin
				deg_q <= ext_bad;
				for (int i = 0; i < 3; i++) begin
					nrm_q[i] <= '0;
				end
			end
			ST_NUM_A, ST_NUM_B: tmp_q <= sum;
			ST_ABS: begin
				rem_q <= sum;
				neg_q <= tmp_q[W-1];
			end
			ST_TEST: begin
				cnt_q <= '0;
				quo_q <= sum[W-1] ? '0 : QUO_ONE;
			end
			ST_DIV: begin
				rem_q <= sum[W-1] ? {rem_q[W-2:0], 1'b0} : sum;
				quo_q <= {quo_q[OUT_FRAC_BITS-1:0], ~sum[W-1]};
				cnt_q <= cnt_q + 1'b1;
			end
			ST_STORE: begin
				nrm_q[axis_q] <= neg_q ? (NW'(0) - quo_ext) : quo_ext;
				axis_q        <= axis_q + 1'b1;
			end
			ST_OUT: begin
				if (out_load) begin
					for (int i = 0; i < 3; i++) begin
						res_q[i] <= nrm_q[i];
					end
					res_deg_q <= deg_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = res_deg_q;

	always_comb begin
		m_tdata = '0;
		for (int i = 0; i < 3; i++) begin
			m_tdata[i*NW +: NW] = res_q[i];
		end
	end

endmodule

// ----- src/vbbn_checker.sv -----
`timescale 1ns / 1ps
module vbbn_checker
	import vbbn_pkg::*;
#(
	parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
	parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF,
	localparam int IN_DATA_W    = ((3 * COORD_WIDTH + 7) / 8) * 8,
	localparam int NW           = OUT_FRAC_BITS + 2,
	localparam int OUT_DATA_W   = ((3 * NW + 7) / 8) * 8
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic [IN_DATA_W-1:0]  s_tdata,   // coord_x, coord_y, coord_z, zero pad
	input logic [1:0]            s_tuser,   // action
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,   // norm_x, norm_y, norm_z, zero pad
	input logic                  m_tuser    // degenerate
);

	// hold a stalled item
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output item changed while stalled");

	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("degenerate item with nonzero coordinates");

	a_convert_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == ACT_CONVERT |=> !s_tready)
		else $error("input still ready after a convert item");

	a_out_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("output item appeared while idle");

endmodule

bind vertex_bounding_box_normalizer vbbn_checker #(
	.COORD_WIDTH(COORD_WIDTH),
	.OUT_FRAC_BITS(OUT_FRAC_BITS)
) u_vbbn_checker (.*);
